>>> hdl/thsr_pkg.sv
// ============================================================================
// thsr_pkg - shared types and constants of the tuple hash segment reducer
// Field widths, register indexes, reduction mode codes, the jump hash LCG
// multiplier and the command and status records of the reduction unit.
// ============================================================================
package thsr_pkg;

   localparam int HASH_W    = 32;
   localparam int SEG_W     = 16;
   localparam int KEY_W     = 64;
   localparam int CSR_IDX_W = 8;
   localparam int RSP_W     = SEG_W + HASH_W;

   // register indexes on the configuration channel
   localparam logic [CSR_IDX_W-1:0] CSR_SEG_COUNT   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REDUCE_MODE = 8'd1;

   // reduction mode codes; the spare code behaves as modulo
   localparam logic [1:0] MODE_JUMP = 2'd0;
   localparam logic [1:0] MODE_MASK = 2'd1;
   localparam logic [1:0] MODE_MOD  = 2'd2;

   // jump hash LCG multiplier, split into 32-bit halves
   localparam logic [KEY_W-1:0]  LCG_MUL    = 64'h27BB_2EE6_87B0_B0FD;
   localparam logic [HASH_W-1:0] LCG_MUL_LO = LCG_MUL[31:0];
   localparam logic [HASH_W-1:0] LCG_MUL_HI = LCG_MUL[63:32];

   // quotient bits produced by the serial divider in each use
   localparam logic [5:0] DIV_MOD_STEPS  = 6'd32;
   localparam logic [5:0] DIV_JUMP_STEPS = 6'd16;

   typedef struct packed {
      logic              start;
      logic              take;
      logic [1:0]        mode;
      logic [SEG_W-1:0]  seg_count;
      logic [HASH_W-1:0] hash;
   } thsr_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [SEG_W-1:0] segment;
   } thsr_sts_type;

endpackage

>>> hdl/tuple_hash_segment_reducer_top.sv
// ============================================================================
// tuple_hash_segment_reducer_top - tuple hash and segment reducer
// Folds attribute hashes into a tuple hash and maps it onto a segment.
// ============================================================================
// Each request carries one attribute hash. A request that is not the last of
// its tuple is folded into the running hash and the block is ready again at
// once. On the last attribute the tuple hash goes to the reduction unit and
// the block stays not ready until the result has been loaded into the
// response register: mask mode goes straight to the load, modulo mode runs
// the serial divider, a check and the load, and jump mode repeats a jump step
// (three passes through the shared 32x32 multiplier, a range check, the
// divider and a check), with roughly ln(segment count) + 1 steps, before the
// load; a final step whose quotient is out of range ends after its range
// check. A waiting response holds nothing back until the next tuple's result
// is ready; requests then wait with that result until the response register
// is free.
// ============================================================================
module tuple_hash_segment_reducer_top (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [thsr_pkg::HASH_W-1:0]    req_tdata,   // [31:0] attr_hash
   input  logic                           req_tuser,   // [0] attr_is_null
   input  logic                           req_tlast,   // last_attr
   // response channel
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [thsr_pkg::RSP_W-1:0]     rsp_tdata,   // [15:0] segment, [47:16] tuple_hash
   // configuration channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [thsr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [thsr_pkg::SEG_W-1:0]     csr_data
);
   import thsr_pkg::*;

   logic [SEG_W-1:0]  seg_count_ff;
   logic [1:0]        reduce_mode_ff;
   logic [HASH_W-1:0] running_ff, running_in;
   logic [HASH_W-1:0] tuple_ff, tuple_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              req_accept;
   logic              slot_free;
   logic [HASH_W-1:0] combined;
   thsr_cmd_type      cmd;
   thsr_sts_type      sts;

   assign csr_ready  = 1'b1;
   assign req_tready = !sts.busy;
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // rotate the running hash and fold in a non-null attribute
   assign combined = {running_ff[30:0], running_ff[31]} ^ (req_tuser ? '0 : req_tdata);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff   <= 16'd1;
         reduce_mode_ff <= MODE_JUMP;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SEG_COUNT:   seg_count_ff   <= csr_data;
            CSR_REDUCE_MODE: reduce_mode_ff <= csr_data[1:0];
            default:         ;
         endcase
      end
   end

   // advance the running hash, clear it at the end of a tuple
   always_comb begin
      running_in = running_ff;
      tuple_in   = tuple_ff;
      if (req_accept) begin
         running_in = req_tlast ? '0 : combined;
         if (req_tlast) begin
            tuple_in = combined;
         end
      end
   end

   // load the response register when a result is ready and the slot is free
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (sts.done && slot_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {tuple_ff, sts.segment};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tuple_ff    <= tuple_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign cmd.start     = req_accept && req_tlast;
   assign cmd.take      = slot_free;
   assign cmd.mode      = reduce_mode_ff;
   assign cmd.seg_count = seg_count_ff;
   assign cmd.hash      = combined;

   thsr_reduce u_reduce (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> hdl/thsr_reduce.sv
// ============================================================================
// thsr_reduce - segment reduction unit
// Sequencer around one shared 32x32 multiplier and one serial restoring
// divider. Reduces a tuple hash by mask, by modulo or by jump consistent hash.
// ============================================================================
module thsr_reduce (
   input  logic                  clock,
   input  logic                  reset,
   input  thsr_pkg::thsr_cmd_type cmd,
   output thsr_pkg::thsr_sts_type sts
);
   import thsr_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL_LL,
      S_MUL_HL,
      S_MUL_LH,
      S_PRE,
      S_DIV,
      S_CHK,
      S_DONE
   } state_type;

   state_type         state_ff, state_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  acc_ff, acc_in;
   logic [SEG_W-1:0]  b_ff, b_in;
   logic [SEG_W-1:0]  n_ff, n_in;
   logic              jump_ff, jump_in;
   logic [HASH_W:0]   rem_ff, rem_in;
   logic [HASH_W-1:0] dvd_ff, dvd_in;
   logic [HASH_W-1:0] div_ff, div_in;
   logic [HASH_W-1:0] quo_ff, quo_in;
   logic [5:0]        cnt_ff, cnt_in;
   logic [SEG_W-1:0]  seg_ff, seg_in;

   logic [HASH_W-1:0] mul_a, mul_b;
   logic [KEY_W-1:0]  prod;
   logic [HASH_W-1:0] jd;
   logic [SEG_W-1:0]  b_next;
   logic [47:0]       jnum;
   logic [47:0]       jlim;
   logic [HASH_W:0]   trial;
   logic              trial_ge;
   logic [SEG_W-1:0]  n_start;

   // shared multiplier: pick the partial product for this step
   always_comb begin
      mul_a = key_ff[31:0];
      mul_b = LCG_MUL_LO;
      case (state_ff)
         S_MUL_HL: mul_a = key_ff[63:32];
         S_MUL_LH: mul_b = LCG_MUL_HI;
         default:  ;
      endcase
   end

   assign prod = {32'd0, mul_a} * {32'd0, mul_b};

   // jump step operands: divisor (key >> 33) + 1, dividend (b + 1) << 31
   assign jd     = {1'b0, key_ff[63:33]} + 32'd1;
   assign b_next = b_ff + 16'd1;
   assign jnum   = {1'b0, b_next, 31'd0};
   assign jlim   = {jd, 16'd0};

   // restoring divider step: shift in the next dividend bit and compare
   assign trial    = {rem_ff[31:0], dvd_ff[31]};
   assign trial_ge = trial >= {1'b0, div_ff};

   // zero segments count as one
   assign n_start = (cmd.seg_count == 16'd0) ? 16'd1 : cmd.seg_count;

   // sequencer
   always_comb begin
      state_in = state_ff;
      key_in   = key_ff;
      acc_in   = acc_ff;
      b_in     = b_ff;
      n_in     = n_ff;
      jump_in  = jump_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      div_in   = div_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      seg_in   = seg_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               n_in = n_start;
               case (cmd.mode)
                  MODE_JUMP: begin
                     key_in   = {32'd0, cmd.hash};
                     b_in     = '0;
                     jump_in  = 1'b1;
                     state_in = S_MUL_LL;
                  end
                  MODE_MASK: begin
                     seg_in   = cmd.hash[15:0] & (n_start - 16'd1);
                     state_in = S_DONE;
                  end
                  default: begin
                     rem_in   = '0;
                     dvd_in   = cmd.hash;
                     div_in   = {16'd0, n_start};
                     quo_in   = '0;
                     cnt_in   = DIV_MOD_STEPS;
                     jump_in  = 1'b0;
                     state_in = S_DIV;
                  end
               endcase
            end
         end
         S_MUL_LL: begin
            acc_in   = prod;
            state_in = S_MUL_HL;
         end
         S_MUL_HL: begin
            acc_in   = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]};
            state_in = S_MUL_LH;
         end
         S_MUL_LH: begin
            key_in   = {acc_ff[63:32] + prod[31:0], acc_ff[31:0]} + 64'd1;
            state_in = S_PRE;
         end
         S_PRE: begin
            // a quotient of 2^16 or more is past any segment count: stop
            if (jnum >= jlim) begin
               seg_in   = b_ff;
               state_in = S_DONE;
            end else begin
               rem_in   = {2'b00, jnum[46:16]};
               dvd_in   = {jnum[15:0], 16'd0};
               div_in   = jd;
               quo_in   = '0;
               cnt_in   = DIV_JUMP_STEPS;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            rem_in = trial_ge ? (trial - {1'b0, div_ff}) : trial;
            dvd_in = {dvd_ff[30:0], 1'b0};
            quo_in = {quo_ff[30:0], trial_ge};
            cnt_in = cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (!jump_ff) begin
               seg_in   = rem_ff[15:0];
               state_in = S_DONE;
            end else if (quo_ff[15:0] < n_ff) begin
               b_in     = quo_ff[15:0];
               state_in = S_MUL_LL;
            end else begin
               seg_in   = b_ff;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (cmd.take) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // hold state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      key_ff  <= key_in;
      acc_ff  <= acc_in;
      b_ff    <= b_in;
      n_ff    <= n_in;
      jump_ff <= jump_in;
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
      seg_ff  <= seg_in;
   end

   assign sts.busy    = (state_ff != S_IDLE);
   assign sts.done    = (state_ff == S_DONE);
   assign sts.segment = seg_ff;

endmodule

>>> hdl/thsr_checker.sv
// ============================================================================
// thsr_checker - port-level checks of the tuple hash segment reducer
// Watches the top level's channels and is bound to it below.
// ============================================================================
module thsr_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tlast,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [thsr_pkg::RSP_W-1:0]     rsp_tdata
);
   import thsr_pkg::*;

   // a last attribute starts a reduction: no request can follow directly
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request taken straight after a last attribute");

   // a new response only appears once requests have been held off by a reduction
   a_rsp_from_reduction: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("response appeared without a reduction in progress");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // reset drops any pending response
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind tuple_hash_segment_reducer_top thsr_checker u_thsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> dv/tb_tuple_hash_segment_reducer_top.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_tuple_hash_segment_reducer_top - tuple hash segment reducer testbench
// Sends attribute requests grouped into tuples and folds them into its own
// copy of the running tuple hash. Each last attribute yields an expected
// segment and tuple hash, which are checked in order against the responses.
// The reduction mode and the segment count are changed between phases while
// the block is idle. Both channels stall at random except in the final phase.
// ============================================================================
module tb_tuple_hash_segment_reducer_top;
   import thsr_pkg::*;

   // jump hash LCG multiplier, an independent copy for the predictor
   localparam logic [63:0] JUMP_LCG_MUL = 64'd2862933555777941757;
   // spare mode code and register indexes that address nothing
   localparam logic [1:0]           MODE_SPARE     = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 8'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_IDX    = 8'hFF;
   // cycles to let the block settle before a register write and at the end
   localparam int SETTLE_CYCLES = 60;

   typedef struct packed {
      logic [SEG_W-1:0]  segment;
      logic [HASH_W-1:0] tuple_hash;
   } tuple_result_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [HASH_W-1:0]    req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 req_tlast  = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b1;
   logic [RSP_W-1:0]     rsp_tdata;
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [SEG_W-1:0]     csr_data   = '0;

   // predictor state: running hash and register copies
   logic [HASH_W-1:0] tuple_acc;
   logic [SEG_W-1:0]  seg_count;
   logic [1:0]        reduce_sel;
   tuple_result_type  expected_tuples[$];

   int  error_count  = 0;
   int  items_sent   = 0;
   bit  quiet_tail   = 1'b0;
   int  req_gap_pct  = 25;

   tuple_hash_segment_reducer_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic logic [SEG_W-1:0] jump_segment(input logic [HASH_W-1:0] h,
                                                     input logic [31:0] n);
      logic [63:0] key;
      logic [63:0] bucket;
      logic [63:0] next_bucket;
      key         = {32'd0, h};
      bucket      = '0;
      next_bucket = '0;
      while (next_bucket < {32'd0, n}) begin
         bucket      = next_bucket;
         key         = key * JUMP_LCG_MUL + 64'd1;
         next_bucket = ((bucket + 64'd1) << 31) / ((key >> 33) + 64'd1);
      end
      return bucket[SEG_W-1:0];
   endfunction

   function automatic logic [SEG_W-1:0] tuple_segment(input logic [HASH_W-1:0] h);
      logic [31:0] n;
      logic [31:0] seg;
      // a zero segment count means one segment
      n = (seg_count == '0) ? 32'd1 : {16'd0, seg_count};
      case (reduce_sel)
         MODE_JUMP: begin
            seg = {16'd0, jump_segment(h, n)};
         end
         MODE_MASK: begin
            seg = h & (n - 32'd1);
         end
         default: begin
            seg = h % n;
         end
      endcase
      return seg[SEG_W-1:0];
   endfunction

   // rotate, fold in a non-null attribute, and close the tuple on the last one
   task automatic fold_attr(input logic [HASH_W-1:0] attr, input logic is_null,
                            input logic last);
      logic [HASH_W-1:0] h;
      tuple_result_type  r;
      h = {tuple_acc[HASH_W-2:0], tuple_acc[HASH_W-1]};
      if (!is_null) begin
         h = h ^ attr;
      end
      if (last) begin
         r.segment    = tuple_segment(h);
         r.tuple_hash = h;
         expected_tuples.push_back(r);
         tuple_acc = '0;
      end else begin
         tuple_acc = h;
      end
   endtask

   // ---------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------
   // send one attribute request, with an optional gap in front of it
   task automatic send_attr(input logic [HASH_W-1:0] attr, input logic is_null,
                            input logic last);
      if (!quiet_tail && $urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= attr;
      req_tuser  <= is_null;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      fold_attr(attr, is_null, last);
      items_sent++;
   endtask

   // hold requests until every expected response has arrived, then settle
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_tuples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [SEG_W-1:0] value);
      wait_idle();
      csr_index <= idx;
      csr_data  <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SEG_COUNT) begin
         seg_count = value;
      end else if (idx == CSR_REDUCE_MODE) begin
         reduce_sel = value[1:0];
      end
   endtask

   function automatic logic [HASH_W-1:0] rand_attr();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         2:       return 32'd1 << $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_tuple();
      int len;
      len = ($urandom_range(9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
         send_attr(rand_attr(), $urandom_range(5) == 0, i == len - 1);
      end
   endtask

   task automatic pick_settings();
      logic [SEG_W-1:0] n;
      case ($urandom_range(7))
         0:       n = '0;
         1:       n = 16'hFFFF;
         2:       n = SEG_W'($urandom_range(1024, 65535));
         3:       n = 16'd1 << $urandom_range(15);
         default: n = SEG_W'($urandom_range(1, 64));
      endcase
      write_reg(CSR_SEG_COUNT, n);
      write_reg(CSR_REDUCE_MODE, {14'($urandom), 2'($urandom_range(3))});
   endtask

   // ---------------------------------------------------------------------
   // Response side: random stalls, then check against the oldest expectation
   // ---------------------------------------------------------------------
   always begin
      @(posedge clock);
      if (!quiet_tail && $urandom_range(4) == 0) begin
         rsp_tready <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
         rsp_tready <= 1'b1;
      end else begin
         repeat ($urandom_range(0, 30)) @(posedge clock);
      end
   end

   always @(posedge clock) begin : check_responses
      tuple_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_tuples.size() == 0) begin
            $error("unexpected response: segment %0d tuple_hash %h",
                   rsp_tdata[SEG_W-1:0], rsp_tdata[RSP_W-1:SEG_W]);
            error_count++;
         end else begin
            want = expected_tuples.pop_front();
            if (rsp_tdata[SEG_W-1:0] !== want.segment) begin
               $error("segment: expected %0d, actual %0d", want.segment,
                      rsp_tdata[SEG_W-1:0]);
               error_count++;
            end
            if (rsp_tdata[RSP_W-1:SEG_W] !== want.tuple_hash) begin
               $error("tuple_hash: expected %h, actual %h", want.tuple_hash,
                      rsp_tdata[RSP_W-1:SEG_W]);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // reset settings: one segment, jump reduction
   task automatic test_reset_settings();
      send_attr(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_attr(32'h1234_5678, 1'b0, 1'b0);
      send_attr(32'hFFFF_FFFF, 1'b1, 1'b1);
   endtask

   // rotation, null attributes and wrap of the running hash
   task automatic test_attr_combine();
      write_reg(CSR_SEG_COUNT, 16'hFFFF);
      write_reg(CSR_REDUCE_MODE, {14'd0, MODE_MASK});
      send_attr(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_attr(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_attr(32'h8000_0000, 1'b0, 1'b1);
      send_attr(32'hA5A5_5A5A, 1'b1, 1'b0);
      send_attr(32'h0000_0000, 1'b1, 1'b1);
      send_attr(32'h0000_0001, 1'b0, 1'b0);
      send_attr(32'h8000_0000, 1'b0, 1'b1);
   endtask

   // every mode, spare code included, at zero, a small even and the largest count
   task automatic test_reduce_modes();
      logic [1:0]       modes[4];
      logic [SEG_W-1:0] counts[3];
      modes  = '{MODE_JUMP, MODE_MASK, MODE_MOD, MODE_SPARE};
      counts = '{16'd0, 16'd12, 16'hFFFF};
      foreach (modes[m]) begin
         write_reg(CSR_REDUCE_MODE, {14'd0, modes[m]});
         foreach (counts[c]) begin
            write_reg(CSR_SEG_COUNT, counts[c]);
            send_attr(rand_attr(), 1'b0, 1'b1);
         end
      end
   endtask

   // writes to indexes beyond the register list must change nothing
   task automatic test_unused_index();
      write_reg(CSR_SEG_COUNT, 16'd10);
      write_reg(CSR_REDUCE_MODE, {14'd0, MODE_MOD});
      write_reg(CSR_UNUSED_IDX, 16'h0003);
      write_reg(CSR_TOP_IDX, 16'h0001);
      send_attr(32'hDEAD_BEEF, 1'b0, 1'b1);
   endtask

   // random tuples over changing settings, with one full drain halfway through
   task automatic test_random_tuples(input int n_items);
      int phase_end;
      int drain_at;
      int phase;
      phase    = 0;
      drain_at = items_sent + n_items / 2;
      n_items  = items_sent + n_items;
      while (items_sent < n_items) begin
         pick_settings();
         req_gap_pct = (phase % 3 == 2) ? 0 : $urandom_range(10, 50);
         phase_end   = items_sent + 60;
         while (items_sent < phase_end && items_sent < n_items) begin
            send_random_tuple();
            if (drain_at != 0 && items_sent >= drain_at) begin
               wait_idle();
               drain_at = 0;
            end
         end
         phase++;
      end
   endtask

   // no stalls on either side at the end of the run
   task automatic test_quiet_tail(input int n_items);
      int stop_at;
      pick_settings();
      quiet_tail = 1'b1;
      stop_at    = items_sent + n_items;
      while (items_sent < stop_at) begin
         send_random_tuple();
      end
   endtask

   initial begin
      tuple_acc  = '0;
      seg_count  = 16'd1;
      reduce_sel = MODE_JUMP;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_settings();
      test_attr_combine();
      test_reduce_modes();
      test_unused_index();
      test_random_tuples(600);
      test_quiet_tail(100);

      wait_idle();
      if (error_count == 0 && expected_tuples.size() == 0) begin
         $display("tuple_hash_segment_reducer_top test passed");
      end else begin
         if (expected_tuples.size() != 0) begin
            $error("%0d expected responses never arrived", expected_tuples.size());
         end
         $display("tuple_hash_segment_reducer_top test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("tuple_hash_segment_reducer_top test failed");
      $finish;
   end

endmodule

>>> tuple_hash_segment_reducer_top.f
hdl/thsr_pkg.sv
hdl/thsr_reduce.sv
hdl/tuple_hash_segment_reducer_top.sv
hdl/thsr_checker.sv
dv/tb_tuple_hash_segment_reducer_top.sv
